// ----- rtl/core/assert_macros.svh -----
// Assertion macros of the line point generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, ignored while reset is held
`define LPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds through reset
`define LPG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LPG_ASSERT(lbl, prop, msg)
`define LPG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/lpg_pkg.sv -----
// Types and constants of the line point generator.
`timescale 1ns / 1ps

package lpg_pkg;

    // Default internal coordinate width
    localparam int COORD_BITS_DEF = 8;

    // Field widths of the words
    typedef logic [7:0]  t_coord;
    typedef logic [15:0] t_ink;

    // Command codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // Command word
    typedef struct packed {
        t_op    op;
        t_coord start_col;
        t_coord start_row;
        t_coord end_col;
        t_coord end_row;
        t_ink   ink;
    } t_lpg_in;

    // Point word
    typedef struct packed {
        t_coord point_col;
        t_coord point_row;
        t_ink   point_ink;
        logic   final_point;
    } t_lpg_out;

    // Axis and direction flags of the line in progress
    typedef struct packed {
        logic row_major;
        logic col_descend;
        logic row_descend;
    } t_lpg_dir;

endpackage

// ----- rtl/core/lpg_stream_if.sv -----
// Valid/ready stream interface carrying one word per handshake.
`timescale 1ns / 1ps

interface lpg_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/line_point_generator.sv -----
// Top level of the line point generator.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// A load word latches both endpoints and a color and gives no point. Each
// step word after it gives the next pixel of the line, one point word per
// step, the last one flagged as the second endpoint; a step while idle gives
// nothing. Each command word is handled in one pass of the stepper between the
// line state registers and the output register, so a word can be taken at every
// clock edge while the point side keeps taking points. The command side is
// ready whenever the output register is empty or is being taken in the same
// cycle. Coordinates are held internally at COORD_BITS bits.
module line_point_generator #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    lpg_stream_if.sink          i_cmd,
    lpg_stream_if.source        o_pnt
);

    // Line state
    logic [COORD_BITS-1:0] r_cur_col,   n_cur_col;
    logic [COORD_BITS-1:0] r_cur_row,   n_cur_row;
    logic [COORD_BITS-1:0] r_stop_col,  n_stop_col;
    logic [COORD_BITS-1:0] r_stop_row,  n_stop_row;
    logic [COORD_BITS-1:0] r_major_span, n_major_span;
    logic [COORD_BITS-1:0] r_minor_span, n_minor_span;
    logic [COORD_BITS-1:0] r_frac,      n_frac;
    lpg_pkg::t_lpg_dir     r_dir,       n_dir;
    logic                  r_busy,      n_busy;
    lpg_pkg::t_ink         r_ink,       n_ink;

    // Output register
    lpg_pkg::t_lpg_out     r_out,       n_out;
    logic                  r_out_valid, n_out_valid;

    lpg_pkg::t_lpg_in      cmd;
    logic                  cmd_acc;
    logic                  is_load;
    logic                  is_emit;
    logic [COORD_BITS-1:0] sc, sr, ec, er, dc, dr;
    logic                  ld_row_major;
    logic [COORD_BITS-1:0] stp_col, stp_row, stp_frac;
    logic                  stp_last;

    assign cmd         = i_cmd.payload;
    assign i_cmd.ready = !r_out_valid || o_pnt.ready;
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign is_load     = cmd_acc && (cmd.op == lpg_pkg::OP_LOAD);
    assign is_emit     = cmd_acc && (cmd.op == lpg_pkg::OP_STEP) && r_busy;

    assign o_pnt.valid   = r_out_valid;
    assign o_pnt.payload = r_out;

    // Load setup: distances and axis choice
    always_comb begin
        sc = COORD_BITS'(cmd.start_col);
        sr = COORD_BITS'(cmd.start_row);
        ec = COORD_BITS'(cmd.end_col);
        er = COORD_BITS'(cmd.end_row);
        dc = (sc > ec) ? sc - ec : ec - sc;
        dr = (sr > er) ? sr - er : er - sr;
        ld_row_major = (dc == '0) || (dr > dc);
    end

    lpg_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .i_cur_col    (r_cur_col),
        .i_cur_row    (r_cur_row),
        .i_stop_col   (r_stop_col),
        .i_stop_row   (r_stop_row),
        .i_major_span (r_major_span),
        .i_minor_span (r_minor_span),
        .i_frac       (r_frac),
        .i_dir        (r_dir),
        .o_nxt_col    (stp_col),
        .o_nxt_row    (stp_row),
        .o_nxt_frac   (stp_frac),
        .o_last       (stp_last)
    );

    // Next line state
    always_comb begin
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_stop_col   = r_stop_col;
        n_stop_row   = r_stop_row;
        n_major_span = r_major_span;
        n_minor_span = r_minor_span;
        n_frac       = r_frac;
        n_dir        = r_dir;
        n_busy       = r_busy;
        n_ink        = r_ink;
        if (is_load) begin
            n_cur_col         = sc;
            n_cur_row         = sr;
            n_stop_col        = ec;
            n_stop_row        = er;
            n_dir.row_major   = ld_row_major;
            n_dir.col_descend = sc > ec;
            n_dir.row_descend = sr > er;
            n_major_span      = ld_row_major ? dr : dc;
            n_minor_span      = ld_row_major ? dc : dr;
            n_frac            = '0;
            n_ink             = cmd.ink;
            n_busy            = 1'b1;
        end else if (is_emit) begin
            if (stp_last) begin
                n_busy = 1'b0;
            end else begin
                n_cur_col = stp_col;
                n_cur_row = stp_row;
                n_frac    = stp_frac;
            end
        end
    end

    // Next output word
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_pnt.ready;
        if (is_emit) begin
            n_out.point_col   = lpg_pkg::t_coord'(r_cur_col);
            n_out.point_row   = lpg_pkg::t_coord'(r_cur_row);
            n_out.point_ink   = r_ink;
            n_out.final_point = stp_last;
            n_out_valid       = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur_col    <= n_cur_col;
        r_cur_row    <= n_cur_row;
        r_stop_col   <= n_stop_col;
        r_stop_row   <= n_stop_row;
        r_major_span <= n_major_span;
        r_minor_span <= n_minor_span;
        r_frac       <= n_frac;
        r_dir        <= n_dir;
        r_ink        <= n_ink;
        r_out        <= n_out;
    end

    // Checks
    `LPG_ASSERT(a_idle_step_silent, (cmd_acc && cmd.op == lpg_pkg::OP_STEP && !r_busy && o_pnt.ready) |=> !r_out_valid, "step while idle produced a point")
    `LPG_ASSERT(a_last_ends_line, (is_emit && stp_last && !is_load) |=> !r_busy, "line still busy after its final point")
    `LPG_ASSERT(a_load_starts_line, is_load |=> (r_busy && r_frac == '0), "load did not start a line")
    `LPG_ASSERT(a_frac_bound, r_busy |-> (r_frac < r_major_span || r_frac == '0), "error accumulator out of range")
    `LPG_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !r_out_valid, "output valid after reset")

endmodule

// ----- rtl/core/lpg_stepper.sv -----
// Next-point logic: advances the major axis and tracks the minor axis error.
`timescale 1ns / 1ps

module lpg_stepper #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] i_cur_col,
    input  logic [COORD_BITS-1:0] i_cur_row,
    input  logic [COORD_BITS-1:0] i_stop_col,
    input  logic [COORD_BITS-1:0] i_stop_row,
    input  logic [COORD_BITS-1:0] i_major_span,
    input  logic [COORD_BITS-1:0] i_minor_span,
    input  logic [COORD_BITS-1:0] i_frac,
    input  lpg_pkg::t_lpg_dir     i_dir,
    output logic [COORD_BITS-1:0] o_nxt_col,
    output logic [COORD_BITS-1:0] o_nxt_row,
    output logic [COORD_BITS-1:0] o_nxt_frac,
    output logic                  o_last
);

    logic [COORD_BITS-1:0] maj;
    logic [COORD_BITS-1:0] mnr;
    logic [COORD_BITS-1:0] maj_nxt;
    logic [COORD_BITS-1:0] mnr_nxt;
    logic                  maj_down;
    logic                  mnr_down;
    logic [COORD_BITS:0]   acc_up;
    logic [COORD_BITS:0]   acc_dn;

    // Pick major and minor coordinates
    always_comb begin
        o_last   = i_dir.row_major ? (i_cur_row == i_stop_row) : (i_cur_col == i_stop_col);
        maj      = i_dir.row_major ? i_cur_row : i_cur_col;
        mnr      = i_dir.row_major ? i_cur_col : i_cur_row;
        maj_down = i_dir.row_major ? i_dir.row_descend : i_dir.col_descend;
        mnr_down = i_dir.row_major ? i_dir.col_descend : i_dir.row_descend;
    end

    // Major moves by one; minor follows the error accumulator
    always_comb begin
        maj_nxt = maj_down ? maj - 1'b1 : maj + 1'b1;
        acc_up  = {1'b0, i_frac} + {1'b0, i_minor_span};
        acc_dn  = {1'b0, i_frac} + {1'b0, i_major_span} - {1'b0, i_minor_span};
        mnr_nxt = mnr;
        if (!mnr_down) begin
            if (acc_up >= {1'b0, i_major_span}) begin
                o_nxt_frac = COORD_BITS'(acc_up - {1'b0, i_major_span});
                mnr_nxt    = mnr + 1'b1;
            end else begin
                o_nxt_frac = COORD_BITS'(acc_up);
            end
        end else begin
            if (i_frac < i_minor_span) begin
                o_nxt_frac = COORD_BITS'(acc_dn);
                mnr_nxt    = mnr - 1'b1;
            end else begin
                o_nxt_frac = i_frac - i_minor_span;
            end
        end
    end

    // Map back to columns and rows
    always_comb begin
        o_nxt_col = i_dir.row_major ? mnr_nxt : maj_nxt;
        o_nxt_row = i_dir.row_major ? maj_nxt : mnr_nxt;
    end

endmodule

// ----- test/line_point_generator_tb.sv -----
// Self-checking testbench of the line point generator: directed lines, then random lines.
`timescale 1ns / 1ps

module line_point_generator_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int ACTIVE_WORDS = 1950;

    logic i_clk;
    logic i_rst_n;

    lpg_stream_if #(.t_payload(lpg_pkg::t_lpg_in))  cmd_if ();
    lpg_stream_if #(.t_payload(lpg_pkg::t_lpg_out)) pnt_if ();

    line_point_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pnt   (pnt_if)
    );

    // Line tracer state, mirrors the block
    lpg_pkg::t_coord pos_col, pos_row, goal_col, goal_row;
    bit              rows_lead, col_down, row_down;
    logic [7:0]      lead_span, side_span;
    logic [8:0]      err_acc;
    bit              drawing;
    lpg_pkg::t_ink   line_ink;

    // Points still to come, oldest first
    lpg_pkg::t_lpg_out point_q[$];

    int         fails;
    int         words_sent;
    int         idle_steps;
    int         lines_loaded;
    int         lines_dropped;
    int         points_seen;
    int         cycle_cnt;
    int         hold_cnt;
    bit         steady;

    lpg_pkg::t_lpg_out got_pt, want_pt;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d points outstanding",
                     cycle_cnt, point_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Gap length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    // Point side back-pressure
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            pnt_if.ready <= 1'b0;
            hold_cnt     <= hold_cnt - 1;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            pnt_if.ready <= 1'b0;
            hold_cnt     <= idle_len() - 1;
        end else begin
            pnt_if.ready <= 1'b1;
        end
    end

    // Advance the tracer by one accepted command word
    task automatic trace_point(input lpg_pkg::t_lpg_in w);
        int                dc, dr, acc;
        bit                last, maj_down, mnr_down;
        lpg_pkg::t_coord   maj, mnr;
        lpg_pkg::t_lpg_out pt;
        if (w.op == lpg_pkg::OP_LOAD) begin
            dc        = (w.start_col > w.end_col) ? w.start_col - w.end_col
                                                  : w.end_col - w.start_col;
            dr        = (w.start_row > w.end_row) ? w.start_row - w.end_row
                                                  : w.end_row - w.start_row;
            if (drawing) lines_dropped++;
            pos_col   = w.start_col;
            pos_row   = w.start_row;
            goal_col  = w.end_col;
            goal_row  = w.end_row;
            col_down  = w.start_col > w.end_col;
            row_down  = w.start_row > w.end_row;
            rows_lead = (dc == 0) || (dr > dc);
            lead_span = rows_lead ? dr[7:0] : dc[7:0];
            side_span = rows_lead ? dc[7:0] : dr[7:0];
            err_acc   = '0;
            line_ink  = w.ink;
            drawing   = 1'b1;
            lines_loaded++;
        end else if (!drawing) begin
            idle_steps++;
        end else begin
            last     = rows_lead ? (pos_row == goal_row) : (pos_col == goal_col);
            maj      = rows_lead ? pos_row : pos_col;
            mnr      = rows_lead ? pos_col : pos_row;
            maj_down = rows_lead ? row_down : col_down;
            mnr_down = rows_lead ? col_down : row_down;
            pt.point_col   = pos_col;
            pt.point_row   = pos_row;
            pt.point_ink   = line_ink;
            pt.final_point = last;
            point_q.push_back(pt);
            if (last) begin
                drawing = 1'b0;
            end else begin
                maj = maj_down ? maj - 8'd1 : maj + 8'd1;
                // error accumulator keeps the minor axis at the floor
                if (!mnr_down) begin
                    acc = err_acc + side_span;
                    if (acc >= lead_span) begin
                        acc = acc - lead_span;
                        mnr = mnr + 8'd1;
                    end
                    err_acc = acc[8:0];
                end else if (err_acc < side_span) begin
                    acc     = err_acc + lead_span - side_span;
                    err_acc = acc[8:0];
                    mnr     = mnr - 8'd1;
                end else begin
                    err_acc = err_acc - side_span;
                end
                if (rows_lead) begin
                    pos_row = maj;
                    pos_col = mnr;
                end else begin
                    pos_col = maj;
                    pos_row = mnr;
                end
            end
        end
    endtask

    // Point checker
    always @(posedge i_clk) begin
        if (i_rst_n && pnt_if.valid && pnt_if.ready) begin
            got_pt = pnt_if.payload;
            points_seen++;
            if (point_q.size() == 0) begin
                $error("unexpected point col=%0d row=%0d", got_pt.point_col,
                       got_pt.point_row);
                fails++;
            end else begin
                want_pt = point_q.pop_front();
                if (got_pt.point_col !== want_pt.point_col) begin
                    $error("point_col expected %0d actual %0d",
                           want_pt.point_col, got_pt.point_col);
                    fails++;
                end
                if (got_pt.point_row !== want_pt.point_row) begin
                    $error("point_row expected %0d actual %0d",
                           want_pt.point_row, got_pt.point_row);
                    fails++;
                end
                if (got_pt.point_ink !== want_pt.point_ink) begin
                    $error("point_ink expected %h actual %h",
                           want_pt.point_ink, got_pt.point_ink);
                    fails++;
                end
                if (got_pt.final_point !== want_pt.final_point) begin
                    $error("final_point expected %0b actual %0b",
                           want_pt.final_point, got_pt.final_point);
                    fails++;
                end
            end
        end
    end

    function automatic lpg_pkg::t_lpg_in load_word(int sc, int sr, int ec, int er, int ink);
        lpg_pkg::t_lpg_in w;
        w.op        = lpg_pkg::OP_LOAD;
        w.start_col = sc[7:0];
        w.start_row = sr[7:0];
        w.end_col   = ec[7:0];
        w.end_row   = er[7:0];
        w.ink       = ink[15:0];
        return w;
    endfunction

    // Step word; the unused fields carry random bits
    function automatic lpg_pkg::t_lpg_in step_word();
        lpg_pkg::t_lpg_in w;
        w    = load_word($urandom, $urandom, $urandom, $urandom, $urandom);
        w.op = lpg_pkg::OP_STEP;
        return w;
    endfunction

    // Send one command word and trace it once taken
    task automatic send_word(input lpg_pkg::t_lpg_in w);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= w;
        do @(posedge i_clk); while (!cmd_if.ready);
        trace_point(w);
        words_sent++;
    endtask

    task automatic send_steps(input int n);
        repeat (n) send_word(step_word());
    endtask

    // Hold the command side until every point has come out
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (point_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_idle_step();
        send_steps(1);
        wait_drained();
    endtask

    // Equal endpoints give one flagged point, then the block is idle
    task automatic test_single_point();
        send_word(load_word(5, 5, 5, 5, 16'h0000));
        send_steps(2);
        wait_drained();
    endtask

    // Full-screen diagonals, the first dropped by a load while busy
    task automatic test_diagonal_reload();
        send_word(load_word(0, 0, 255, 255, 16'hFFFF));
        send_steps(2);
        send_word(load_word(255, 0, 0, 255, 16'hA5A5));
        send_steps(2);
        wait_drained();
    endtask

    // Vertical, shallow and steep lines, with columns and rows each run both up and down
    task automatic test_axis_lines();
        send_word(load_word(255, 255, 255, 252, 16'h5A5A));
        send_steps(4);
        send_word(load_word(0, 9, 4, 7, 16'h1234));
        send_steps(5);
        send_word(load_word(10, 14, 9, 18, 16'h8001));
        send_steps(5);
        wait_drained();
    endtask

    function automatic int near_coord(int base, int reach);
        int v;
        v = base + $urandom_range(0, 2 * reach) - reach;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    // Random lines: mostly short and complete, some cut off, some noise
    task automatic test_random_lines();
        int               r, reach, sc, sr, ec, er;
        lpg_pkg::t_lpg_in w;
        while (words_sent - idle_steps < ACTIVE_WORDS) begin
            steady = ($urandom_range(0, 99) < 15);
            r      = $urandom_range(0, 99);
            if (r < 5) begin
                // noise words with every field random
                repeat ($urandom_range(1, 4)) begin
                    w    = load_word($urandom, $urandom, $urandom, $urandom, $urandom);
                    w.op = lpg_pkg::t_op'($urandom_range(0, 1));
                    send_word(w);
                end
            end else begin
                r     = $urandom_range(0, 99);
                reach = (r < 80) ? 6 : 40;
                sc    = $urandom_range(0, 255);
                sr    = $urandom_range(0, 255);
                if (r < 95) begin
                    ec = near_coord(sc, reach);
                    er = near_coord(sr, reach);
                end else begin
                    ec = $urandom_range(0, 255);
                    er = $urandom_range(0, 255);
                end
                send_word(load_word(sc, sr, ec, er, $urandom));
                if ($urandom_range(0, 99) < 10) begin
                    send_steps($urandom_range(0, lead_span));
                end else begin
                    while (drawing) send_steps(1);
                    if ($urandom_range(0, 99) < 20) send_steps($urandom_range(1, 2));
                end
            end
            if ($urandom_range(0, 99) < 3) wait_drained();
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        pnt_if.ready   = 1'b0;
        fails          = 0;
        words_sent     = 0;
        idle_steps     = 0;
        lines_loaded   = 0;
        lines_dropped  = 0;
        points_seen    = 0;
        cycle_cnt      = 0;
        hold_cnt       = 0;
        steady         = 1'b0;
        drawing        = 1'b0;
        pos_col        = '0;
        pos_row        = '0;
        goal_col       = '0;
        goal_row       = '0;
        rows_lead      = 1'b0;
        col_down       = 1'b0;
        row_down       = 1'b0;
        lead_span      = '0;
        side_span      = '0;
        err_acc        = '0;
        line_ink       = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_step();
        test_single_point();
        test_diagonal_reload();
        test_axis_lines();
        test_random_lines();

        repeat (10) @(posedge i_clk);
        if (point_q.size() != 0) begin
            $error("%0d expected points never came", point_q.size());
            fails++;
        end

        $display("Drew %0d lines (%0d cut off by a reload), %0d points checked,",
                 lines_loaded, lines_dropped, points_seen);
        $display("%0d command words in all, %0d steps while idle, %0d mismatches",
                 words_sent, idle_steps, fails);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lpg_pkg.sv
rtl/core/lpg_stream_if.sv
rtl/core/lpg_stepper.sv
rtl/core/line_point_generator.sv
test/line_point_generator_tb.sv
